[rtl/core/bcc_pkg.sv]
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared constants, codes and payload types of the chirp coefficient pipeline.
// ----------------------------------------------------------------------------
package bcc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int OUT_W     = FRAC_BITS + 2;
    localparam int AMP_W     = FRAC_BITS + 1;
    localparam int MAX_SIZE  = 65536;
    localparam int IDX_W     = 16;
    localparam int N_W       = 16;
    localparam int M_W       = 17;
    localparam int D_W       = 17;      // divisor 2n
    localparam int WORD_W    = 32;      // dividend bits fed to the divider row
    localparam int DIV_STEPS = 32;      // cells per division
    localparam int TERMS     = 6;       // Horner steps per lane
    localparam int Q_W       = 30;      // Q30 magnitude below 1.0
    localparam int T_W       = 31;      // Q30 value up to and including 1.0

    localparam logic [31:0]    PI_Q30  = 32'd3373259426;
    localparam logic [T_W-1:0] Q30_ONE = T_W'(1) << 30;

    localparam logic [2:0] CFG_SIZE_N    = 3'd0;
    localparam logic [2:0] CFG_SIZE_M    = 3'd1;
    localparam logic [2:0] CFG_INVERSE   = 3'd2;
    localparam logic [2:0] CFG_AMPLITUDE = 3'd3;

    typedef struct packed {
        logic zero;     // result forced to zero
        logic oor;      // index not below m
    } flags_t;

    typedef struct packed {
        flags_t         flags;
        logic [2:0]     oct;
        logic [Q_W-1:0] x;
        logic [Q_W-1:0] x2;
        logic [T_W-1:0] ts;
        logic [T_W-1:0] tc;
    } trig_t;

    // Horner divisors, innermost term first
    function automatic int sin_div(input int i);
        int r;
        case (i)
            0:       r = 156;
            1:       r = 110;
            2:       r = 72;
            3:       r = 42;
            4:       r = 20;
            default: r = 6;
        endcase
        return r;
    endfunction

    function automatic int cos_div(input int i);
        int r;
        case (i)
            0:       r = 132;
            1:       r = 90;
            2:       r = 56;
            3:       r = 30;
            4:       r = 12;
            default: r = 2;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/bcc_div_cell.sv]
// ----------------------------------------------------------------------------
// bcc_div_cell
// One restoring-division step: shifts in one dividend bit, emits one quotient bit.
// ----------------------------------------------------------------------------
module bcc_div_cell
    import bcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [D_W-1:0]    divisor,
    input  logic              valid_in,
    input  logic [D_W-1:0]    rem_in,
    input  logic [WORD_W-1:0] word_in,
    input  logic [WORD_W-1:0] quot_in,
    input  flags_t            flags_in,
    output logic              valid_out,
    output logic [D_W-1:0]    rem_out,
    output logic [WORD_W-1:0] word_out,
    output logic [WORD_W-1:0] quot_out,
    output flags_t            flags_out
);

    logic              valid_reg;
    logic [D_W-1:0]    rem_reg, rem_next;
    logic [WORD_W-1:0] word_reg, quot_reg;
    flags_t            flags_reg;
    logic [D_W:0]      trial;
    logic              fits;

    assign trial    = {rem_in, word_in[WORD_W-1]};
    assign fits     = trial >= {1'b0, divisor};
    assign rem_next = fits ? D_W'(trial - {1'b0, divisor}) : trial[D_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg   <= rem_next;
            word_reg  <= {word_in[WORD_W-2:0], 1'b0};
            quot_reg  <= {quot_in[WORD_W-2:0], fits};
            flags_reg <= flags_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign word_out  = word_reg;
    assign quot_out  = quot_reg;
    assign flags_out = flags_reg;

endmodule

[rtl/core/bcc_horner_cell.sv]
// ----------------------------------------------------------------------------
// bcc_horner_cell
// One Horner step for the sine and cosine lanes: t = 1 - x2*t/C, two stages.
// ----------------------------------------------------------------------------
module bcc_horner_cell
    import bcc_pkg::*;
#(
    parameter int SIN_C = 6,
    parameter int COS_C = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  valid_in,
    input  trig_t trig_in,
    output logic  valid_out,
    output trig_t trig_out
);

    // exact floor division by multiply with ceil(2^sh/C)
    localparam int S_SH = 30 + $clog2(SIN_C);
    localparam int C_SH = 30 + $clog2(COS_C);
    localparam logic [T_W-1:0] S_MUL = T_W'(((64'd1 << S_SH) + SIN_C - 1) / SIN_C);
    localparam logic [T_W-1:0] C_MUL = T_W'(((64'd1 << C_SH) + COS_C - 1) / COS_C);

    logic           a_valid_reg, b_valid_reg;
    trig_t          a_trig_reg, b_trig_reg;
    logic [Q_W-1:0] ps_reg, pc_reg;
    logic [60:0]    mul_s, mul_c, rec_s, rec_c;
    logic [Q_W-1:0] q_s, q_c;
    trig_t          b_trig_next;

    assign mul_s = 61'(trig_in.x2) * 61'(trig_in.ts);
    assign mul_c = 61'(trig_in.x2) * 61'(trig_in.tc);

    assign rec_s = 61'(ps_reg) * 61'(S_MUL);
    assign rec_c = 61'(pc_reg) * 61'(C_MUL);
    assign q_s   = Q_W'(rec_s >> S_SH);
    assign q_c   = Q_W'(rec_c >> C_SH);

    always_comb
    begin
        b_trig_next    = a_trig_reg;
        b_trig_next.ts = Q30_ONE - {1'b0, q_s};
        b_trig_next.tc = Q30_ONE - {1'b0, q_c};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= valid_in;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_trig_reg <= trig_in;
            ps_reg     <= mul_s[59:30];
            pc_reg     <= mul_c[59:30];
            b_trig_reg <= b_trig_next;
        end
    end

    assign valid_out = b_valid_reg;
    assign trig_out  = b_trig_reg;

endmodule

[rtl/core/bluestein_chirp_coefficient.sv]
// ----------------------------------------------------------------------------
// bluestein_chirp_coefficient
// Circulant-embedded Bluestein chirp coefficient generator, one index per cycle.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  cfg     | cfg_valid/cfg_ready  | cfg_index[2:0], cfg_data[16:0]
//  in      | in_valid/in_ready    | index[15:0]
//  out     | out_valid/out_ready  | real_part[17:0], imag_part[17:0], out_of_range
//
//  Throughput: one transfer per cycle in and out while the pipe is not stalled.
//  The pipe is a row of cells: two 32-cell restoring-division rows
//  (e*e mod 2n, then the phase quotient), then six Horner cells for sin/cos.
//  Stalls: the whole pipe holds while the output register is full and not
//  taken; in_ready = !out_valid || out_ready. cfg_ready is always high.
//  Reset clears all valid bits and loads n=1, m=1, forward mode, amplitude 1.0.
//  The user must write registers only while the pipe is empty; not enforced.
//
module bluestein_chirp_coefficient
    import bcc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [M_W-1:0]   cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [IDX_W-1:0] index,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] real_part,
    output logic [OUT_W-1:0] imag_part,
    output logic             out_of_range
);

    localparam int NCELL = 2 * DIV_STEPS;
    localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(1) << FRAC_BITS;

    // ---------------- configuration registers ----------------
    logic [N_W-1:0]   size_n_reg;
    logic [M_W-1:0]   size_m_reg;
    logic             inverse_reg;
    logic [AMP_W-1:0] amp_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_n_reg  <= N_W'(1);
            size_m_reg  <= M_W'(1);
            inverse_reg <= 1'b0;
            amp_reg     <= AMP_ONE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SIZE_N:    size_n_reg  <= cfg_data[N_W-1:0];
                CFG_SIZE_M:    size_m_reg  <= cfg_data;
                CFG_INVERSE:   inverse_reg <= cfg_data[0];
                CFG_AMPLITUDE: amp_reg     <= cfg_data[AMP_W-1:0];
                default:       ;
            endcase
        end
    end

    // effective settings: n of zero acts as one, m and amplitude saturate
    logic [N_W-1:0]   n_eff;
    logic [M_W-1:0]   m_eff;
    logic [D_W-1:0]   two_n;
    logic [AMP_W-1:0] amp_eff;

    assign n_eff   = (size_n_reg == '0) ? N_W'(1) : size_n_reg;
    assign m_eff   = ({8'd0, size_m_reg} > 25'(MAX_SIZE)) ? M_W'(MAX_SIZE) : size_m_reg;
    assign two_n   = {n_eff, 1'b0};
    assign amp_eff = (amp_reg > AMP_ONE) ? AMP_ONE : amp_reg;

    // global advance: the whole pipe moves when the output slot can take data
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // ---------------- entry: region decode ----------------
    logic           v0_reg;
    logic [N_W-1:0] e0_reg;
    flags_t         f0_reg;
    logic [N_W-1:0] e0_next;
    flags_t         f0_next;
    logic           mirror, direct;

    // mirrored region: k >= m-n+1, i.e. k+n > m
    assign mirror = (18'(index) + 18'(n_eff)) > 18'(m_eff);
    assign direct = 17'(index) < 17'(n_eff);

    always_comb
    begin
        f0_next.oor  = 17'(index) >= m_eff;
        f0_next.zero = f0_next.oor || (!mirror && !direct);
        e0_next      = mirror ? N_W'(m_eff - 17'(index)) : index;
    end

    // ---------------- square ----------------
    logic              v1_reg;
    logic [WORD_W-1:0] sq1_reg;
    flags_t            f1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e0_reg  <= e0_next;
            f0_reg  <= f0_next;
            sq1_reg <= WORD_W'(e0_reg) * WORD_W'(e0_reg);
            f1_reg  <= f0_reg;
        end
    end

    // ---------------- division rows ----------------
    // cells 0..31: remainder of e*e by 2n; cells 32..63: (r*2^32 + n) / 2n
    logic              dv_in   [NCELL];
    logic [D_W-1:0]    drem_in [NCELL];
    logic [WORD_W-1:0] dword_in[NCELL];
    logic [WORD_W-1:0] dquot_in[NCELL];
    flags_t            dflg_in [NCELL];
    logic              dv_out   [NCELL];
    logic [D_W-1:0]    drem_out [NCELL];
    logic [WORD_W-1:0] dword_out[NCELL];
    logic [WORD_W-1:0] dquot_out[NCELL];
    flags_t            dflg_out [NCELL];

    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++)
        begin : g_div
            if (gi == 0)
            begin : g_first
                assign dv_in[gi]    = v1_reg;
                assign drem_in[gi]  = '0;
                assign dword_in[gi] = sq1_reg;
                assign dquot_in[gi] = '0;
                assign dflg_in[gi]  = f1_reg;
            end
            else if (gi == DIV_STEPS)
            begin : g_turn
                assign dv_in[gi]    = dv_out[gi-1];
                assign drem_in[gi]  = drem_out[gi-1];
                assign dword_in[gi] = WORD_W'(n_eff);
                assign dquot_in[gi] = '0;
                assign dflg_in[gi]  = dflg_out[gi-1];
            end
            else
            begin : g_mid
                assign dv_in[gi]    = dv_out[gi-1];
                assign drem_in[gi]  = drem_out[gi-1];
                assign dword_in[gi] = dword_out[gi-1];
                assign dquot_in[gi] = dquot_out[gi-1];
                assign dflg_in[gi]  = dflg_out[gi-1];
            end

            bcc_div_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .divisor   (two_n),
                .valid_in  (dv_in[gi]),
                .rem_in    (drem_in[gi]),
                .word_in   (dword_in[gi]),
                .quot_in   (dquot_in[gi]),
                .flags_in  (dflg_in[gi]),
                .valid_out (dv_out[gi]),
                .rem_out   (drem_out[gi]),
                .word_out  (dword_out[gi]),
                .quot_out  (dquot_out[gi]),
                .flags_out (dflg_out[gi])
            );
        end
    endgenerate

    // ---------------- phase fold, radians, x^2 ----------------
    logic [WORD_W-1:0] ph;
    logic [Q_W-1:0]    u_next;
    logic              p1_v_reg, p2_v_reg, p3_v_reg;
    logic [2:0]        p1_oct_reg, p2_oct_reg;
    flags_t            p1_f_reg, p2_f_reg;
    logic [Q_W-1:0]    u_reg, x_reg;
    logic [61:0]       xprod;
    logic [59:0]       x2prod;
    trig_t             p3_trig_reg;

    assign ph     = inverse_reg ? (WORD_W'(0) - dquot_out[NCELL-1]) : dquot_out[NCELL-1];
    // odd octants run the angle backward from the octant edge
    assign u_next = ph[29] ? (Q_W'(1) << 29) - {1'b0, ph[28:0]} : {1'b0, ph[28:0]};
    assign xprod  = 62'(u_reg) * 62'(PI_Q30) + (62'(1) << 30);
    assign x2prod = 60'(x_reg) * 60'(x_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_v_reg <= dv_out[NCELL-1];
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg            <= u_next;
            p1_oct_reg       <= ph[31:29];
            p1_f_reg         <= dflg_out[NCELL-1];
            x_reg            <= xprod[60:31];
            p2_oct_reg       <= p1_oct_reg;
            p2_f_reg         <= p1_f_reg;
            p3_trig_reg.flags <= p2_f_reg;
            p3_trig_reg.oct  <= p2_oct_reg;
            p3_trig_reg.x    <= x_reg;
            p3_trig_reg.x2   <= x2prod[59:30];
            p3_trig_reg.ts   <= Q30_ONE;
            p3_trig_reg.tc   <= Q30_ONE;
        end
    end

    // ---------------- Horner row ----------------
    logic  hv[TERMS+1];
    trig_t ht[TERMS+1];

    assign hv[0] = p3_v_reg;
    assign ht[0] = p3_trig_reg;

    generate
        for (gi = 0; gi < TERMS; gi++)
        begin : g_horner
            bcc_horner_cell #(
                .SIN_C (sin_div(gi)),
                .COS_C (cos_div(gi))
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .valid_in  (hv[gi]),
                .trig_in   (ht[gi]),
                .valid_out (hv[gi+1]),
                .trig_out  (ht[gi+1])
            );
        end
    endgenerate

    // ---------------- sine, octant mapping, amplitude, output ----------------
    logic           s_v_reg, m_v_reg;
    logic [60:0]    snprod;
    logic [T_W-1:0] sn_reg, cs_reg;
    logic [2:0]     s_oct_reg;
    flags_t         s_f_reg, m_f_reg;
    logic           swap, cneg, sneg;
    logic [T_W-1:0] cv, sv;
    logic [47:0]    pr_reg, pi_reg;
    logic           cneg_reg, sneg_reg;
    logic [48:0]    rr, ri;
    logic [OUT_W-1:0] mag_r, mag_i;
    logic [OUT_W-1:0] real_reg, imag_reg;
    logic             oor_reg;

    assign snprod = 61'(ht[TERMS].x) * 61'(ht[TERMS].ts);

    // octants 1,2,5,6 swap lanes; 2..5 negate cos; 4..7 negate sin
    assign swap = s_oct_reg[0] ^ s_oct_reg[1];
    assign cneg = s_oct_reg[2] ^ s_oct_reg[1];
    assign sneg = s_oct_reg[2];
    assign cv   = swap ? sn_reg : cs_reg;
    assign sv   = swap ? cs_reg : sn_reg;

    assign rr    = 49'(pr_reg) + (49'(1) << 29);
    assign ri    = 49'(pi_reg) + (49'(1) << 29);
    assign mag_r = rr[47:30];
    assign mag_i = ri[47:30];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_v_reg       <= 1'b0;
            m_v_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s_v_reg       <= hv[TERMS];
            m_v_reg       <= s_v_reg;
            out_valid_reg <= m_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sn_reg    <= snprod[60:30];
            cs_reg    <= ht[TERMS].tc;
            s_oct_reg <= ht[TERMS].oct;
            s_f_reg   <= ht[TERMS].flags;
            pr_reg    <= 48'(amp_eff) * 48'(cv);
            pi_reg    <= 48'(amp_eff) * 48'(sv);
            cneg_reg  <= cneg;
            sneg_reg  <= sneg;
            m_f_reg   <= s_f_reg;
            oor_reg   <= m_f_reg.oor;
            if (m_f_reg.zero)
            begin
                real_reg <= '0;
                imag_reg <= '0;
            end
            else
            begin
                real_reg <= cneg_reg ? OUT_W'(~mag_r + OUT_W'(1)) : mag_r;
                imag_reg <= sneg_reg ? OUT_W'(~mag_i + OUT_W'(1)) : mag_i;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign real_part    = real_reg;
    assign imag_part    = imag_reg;
    assign out_of_range = oor_reg;

endmodule

[rtl/core/bcc_checker.sv]
// ----------------------------------------------------------------------------
// bcc_checker
// Port-level checks of the chirp coefficient generator, bound to the top level.
// ----------------------------------------------------------------------------
module bcc_checker
    import bcc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [OUT_W-1:0] real_part,
    input logic [OUT_W-1:0] imag_part,
    input logic             out_of_range
);

    localparam logic signed [OUT_W-1:0] LIM = OUT_W'(1) << FRAC_BITS;

    // out-of-range results carry a zero coefficient
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> real_part == '0 && imag_part == '0)
        else $error("out_of_range with nonzero coefficient");

    // coefficient magnitude never exceeds 1.0
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $signed(real_part) <= LIM && $signed(real_part) >= -LIM
                   && $signed(imag_part) <= LIM && $signed(imag_part) >= -LIM)
        else $error("coefficient out of Q1.16 range");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(real_part)
                                 && $stable(imag_part) && $stable(out_of_range))
        else $error("stalled result changed");

    // input side is never blocked while the output slot is free
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with empty output slot");

endmodule

bind bluestein_chirp_coefficient bcc_checker u_bcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .real_part    (real_part),
    .imag_part    (imag_part),
    .out_of_range (out_of_range)
);

[test/tb_bluestein_chirp_coefficient.sv]
// ----------------------------------------------------------------------------
// tb_bluestein_chirp_coefficient
// Self-checking bench for the Bluestein chirp coefficient generator. Each
// accepted index is predicted in integer fixed point. The prediction is checked
// exactly, field by field and in order, against the output transfers.
// Random idling and stalls are applied on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bluestein_chirp_coefficient;
    import bcc_pkg::*;

    // register indexes that the block ignores
    localparam logic [2:0] CFG_SPARE_LO = 3'd4;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;
    localparam int         DRAIN_CYCLES = 96;   // longer than the pipe latency
    localparam int         LONG_HOLD    = 400;

    typedef struct {
        logic [OUT_W-1:0] re;
        logic [OUT_W-1:0] im;
        logic             oor;
    } coef_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [2:0]       cfg_index = '0;
    logic [M_W-1:0]   cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [IDX_W-1:0] index = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [OUT_W-1:0] real_part;
    logic [OUT_W-1:0] imag_part;
    logic             out_of_range;

    // shadow of the block's registers, written only while the pipe is empty
    logic [N_W-1:0]   reg_n   = 16'd1;
    logic [M_W-1:0]   reg_m   = 17'd1;
    logic             reg_inv = 1'b0;
    logic [AMP_W-1:0] reg_amp = 17'd65536;

    logic [IDX_W-1:0] index_q[$];      // indexes not yet offered
    coef_t            coef_q[$];       // coefficients still owed by the block

    int  send_gap = 0;
    int  recv_gap = 0;
    int  rg;
    logic steady = 1'b0;        // no idling on either side
    logic hold_req = 1'b0;      // ask the receiver for one long hold-off
    int  mismatches = 0;
    int  n_coef = 0;
    int  n_oor = 0;
    int  n_gap_zero = 0;

    bluestein_chirp_coefficient u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .index        (index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .real_part    (real_part),
        .imag_part    (imag_part),
        .out_of_range (out_of_range)
    );

    always #2 clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap(input logic no_idle);
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic longint unsigned qmul(input longint unsigned a, input longint unsigned b);
        return (a * b) >> 30;
    endfunction

    // amplitude * trig, rounded, sign applied, cut to the output width
    function automatic logic [OUT_W-1:0] scale_out(input longint unsigned amp,
                                                   input longint unsigned trig,
                                                   input logic neg);
        longint unsigned mag;
        mag = (amp * trig + (64'd1 << 29)) >> 30;
        return neg ? OUT_W'(-mag) : OUT_W'(mag);
    endfunction

    function automatic coef_t chirp_coef(input logic [IDX_W-1:0] k);
        longint unsigned sdiv[6] = '{156, 110, 72, 42, 20, 6};
        longint unsigned cdiv[6] = '{132, 90, 56, 30, 12, 2};
        longint unsigned one = 64'd1 << 30;
        longint unsigned n, m, amp, e, two_n, r, ph, u, x, x2, t, sn, cs, cv, sv;
        logic [2:0] oct;
        logic cneg, sneg;
        coef_t c;
        c.re = '0;
        c.im = '0;
        c.oor = 1'b0;
        n = (reg_n == 0) ? 1 : reg_n;
        m = (reg_m > MAX_SIZE) ? MAX_SIZE : reg_m;
        amp = (reg_amp > (1 << FRAC_BITS)) ? (1 << FRAC_BITS) : reg_amp;
        if (k >= m) begin
            c.oor = 1'b1;
            return c;
        end
        // mirrored region takes priority where it overlaps the direct one
        if (longint'(k) >= longint'(m) - longint'(n) + 1)
            e = m - k;
        else if (k < n)
            e = k;
        else
            return c;
        two_n = 2 * n;
        r = (e * e) % two_n;
        ph = (((r << 32) + n) / two_n) & 64'hFFFF_FFFF;
        if (reg_inv)
            ph = (-ph) & 64'hFFFF_FFFF;
        oct = ph[31:29];
        u = ph & ((64'd1 << 29) - 1);
        if (oct[0])
            u = (64'd1 << 29) - u;
        x = (u * PI_Q30 + (64'd1 << 30)) >> 31;
        x2 = qmul(x, x);
        t = one;
        for (int i = 0; i < 6; i++)
            t = one - qmul(x2, t) / sdiv[i];
        sn = qmul(x, t);
        t = one;
        for (int i = 0; i < 6; i++)
            t = one - qmul(x2, t) / cdiv[i];
        cs = t;
        // octants 1,2,5,6 swap sin and cos
        if (oct == 3'd1 || oct == 3'd2 || oct == 3'd5 || oct == 3'd6) begin
            cv = sn;
            sv = cs;
        end else begin
            cv = cs;
            sv = sn;
        end
        cneg = (oct >= 3'd2 && oct <= 3'd5);
        sneg = oct[2];
        c.re = scale_out(amp, cv, cneg);
        c.im = scale_out(amp, sv, sneg);
        return c;
    endfunction

    // Driver: predicts on each input transfer, then offers the next index
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (in_valid && in_ready)
                coef_q.push_back(chirp_coef(index));
            if (in_valid && !in_ready) begin
                // hold payload until the block takes it
            end else if (send_gap > 0) begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (index_q.size() > 0) begin
                index    <= index_q.pop_front();
                in_valid <= 1'b1;
                send_gap <= pick_gap(steady);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each output transfer, then decides on the next stall
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_gap  <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (coef_q.size() == 0) begin
                    $display("%0t: unexpected result re=%h im=%h oor=%b",
                             $time, real_part, imag_part, out_of_range);
                    mismatches++;
                end else begin
                    coef_t c;
                    c = coef_q.pop_front();
                    n_coef++;
                    if (c.oor)
                        n_oor++;
                    else if (c.re == 0 && c.im == 0)
                        n_gap_zero++;
                    if (real_part !== c.re) begin
                        $display("%0t: real_part expected %h actual %h",
                                 $time, c.re, real_part);
                        mismatches++;
                    end
                    if (imag_part !== c.im) begin
                        $display("%0t: imag_part expected %h actual %h",
                                 $time, c.im, imag_part);
                        mismatches++;
                    end
                    if (out_of_range !== c.oor) begin
                        $display("%0t: out_of_range expected %b actual %b",
                                 $time, c.oor, out_of_range);
                        mismatches++;
                    end
                end
            end
            if (hold_req) begin
                recv_gap  <= LONG_HOLD;
                out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap  <= recv_gap - 1;
                out_ready <= 1'b0;
            end else if (out_valid && out_ready) begin
                rg = pick_gap(steady);
                recv_gap  <= rg;
                out_ready <= (rg == 0);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [M_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        forever begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        case (idx)
            CFG_SIZE_N:    reg_n   = data[N_W-1:0];
            CFG_SIZE_M:    reg_m   = data;
            CFG_INVERSE:   reg_inv = data[0];
            CFG_AMPLITUDE: reg_amp = data;
            default:       ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic setup(input logic [M_W-1:0] n, input logic [M_W-1:0] m,
                         input logic inv, input logic [M_W-1:0] amp);
        write_reg(CFG_SIZE_N, n);
        write_reg(CFG_SIZE_M, m);
        write_reg(CFG_INVERSE, {16'd0, inv});
        write_reg(CFG_AMPLITUDE, amp);
    endtask

    // wait until every offered index has produced its result, then let the pipe settle
    task automatic drain();
        forever begin
            @(posedge clk);
            if (index_q.size() == 0 && !in_valid && coef_q.size() == 0)
                break;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic offer(input logic [IDX_W-1:0] k);
        index_q.push_back(k);
    endtask

    initial begin
        int n, m, cnt;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset values: n=1, m=1
        offer(16'd0); offer(16'd1); offer(16'hFFFF);
        drain();

        // direct, zero and mirrored regions
        setup(17'd5, 17'd16, 1'b0, 17'd65536);
        offer(16'd0); offer(16'd3); offer(16'd4); offer(16'd5);
        offer(16'd11); offer(16'd12); offer(16'd15); offer(16'd16);
        drain();

        // overlapping regions, inverse mode
        setup(17'd5, 17'd8, 1'b1, 17'd40000);
        offer(16'd4); offer(16'd7);
        drain();

        // largest sizes
        setup(17'd32768, 17'd65536, 1'b0, 17'd65536);
        offer(16'd0); offer(16'd32767); offer(16'd32768); offer(16'd32769);
        offer(16'hFFFF);
        drain();

        // zero n and m, zero amplitude, ignored register writes
        setup(17'd0, 17'd0, 1'b1, 17'd0);
        write_reg(CFG_SPARE_LO, 17'h1FFFF);
        write_reg(CFG_SPARE_HI, 17'h0AAAA);
        offer(16'd0); offer(16'hFFFF);
        drain();

        // saturation of oversized m and amplitude, largest n
        setup(17'h1FFFF, 17'h1FFFF, 1'b0, 17'h1FFFF);
        offer(16'hFFFF); offer(16'd1);
        drain();

        // random phases
        for (int ph = 0; ph < 12; ph++) begin
            int sel;
            sel = $urandom_range(0, 9);
            if (sel < 6)
                n = $urandom_range(1, 200);
            else if (sel < 9)
                n = $urandom_range(1, 32768);
            else
                n = $urandom_range(0, 65535);
            // circulant length as normally chosen: power of two at least 2n-1
            m = 1;
            while (m < 2 * n - 1)
                m = m * 2;
            if ($urandom_range(0, 4) == 0)
                m = $urandom_range(0, 131071);
            setup(n[M_W-1:0], m[M_W-1:0], 1'($urandom_range(0, 1)),
                  ($urandom_range(0, 3) == 0) ? M_W'($urandom_range(0, 131071))
                                              : M_W'($urandom_range(0, 65536)));
            steady <= (ph % 4 == 3);
            cnt = 100;
            for (int i = 0; i < cnt; i++) begin
                if (m > 0 && $urandom_range(0, 9) < 8)
                    offer(IDX_W'($urandom_range(0, (m > 65536 ? 65536 : m) - 1)));
                else
                    offer(IDX_W'($urandom));
                // receiver holds off long while the sender keeps offering
                if (ph == 2 && i == 20) begin
                    @(posedge clk);
                    hold_req <= 1'b1;
                    @(posedge clk);
                    hold_req <= 1'b0;
                end
                // sender pauses until every result is back
                if (ph == 5 && i == 50) begin
                    forever begin
                        @(posedge clk);
                        if (index_q.size() == 0 && !in_valid && coef_q.size() == 0)
                            break;
                    end
                end
            end
            drain();
        end
        steady <= 1'b0;
        drain();

        $display("Checked %0d coefficients: %0d out of range, %0d in the zero gap,",
                 n_coef, n_oor, n_gap_zero);
        $display("over 18 register settings with random idling on both sides.");
        if (mismatches == 0 && coef_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout");
        $display("Mismatches found");
        $finish;
    end

endmodule
